// File: src/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types and constants for the page translation block with LRU replacement.
// ----------------------------------------------------------------------------
package ptl_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_SPACE_LIMIT = 2'd0;
    localparam logic [1:0] REG_PAGE_SHIFT  = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd2;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_SCAN,
        ST_INVAL,
        ST_EVICT,
        ST_DONE
    } t_state;

endpackage

// File: src/ptl_ram.sv
// ----------------------------------------------------------------------------
// ptl_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // registered read, old word returned during a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/ptl_front.sv
// ----------------------------------------------------------------------------
// ptl_front
// Accepts addresses, checks the range and queues each masked address with
// its range-error flag in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ptl_front #(
    parameter int VIRT_PAGES = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_virt_addr,
    input  logic [32:0]           i_space_limit,
    input  logic [4:0]            i_page_shift,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output logic                  o_q_err,
    output logic [31:0]           o_q_addr
);
    logic [1:0]  r_cnt;
    logic        r_rd;
    logic        r_err [2];
    logic [31:0] r_addr [2];
    logic        w_push;
    logic        w_err;
    logic [63:0] w_pnum;
    logic [63:0] w_a64;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_err   = r_err[r_rd];
    assign o_q_addr  = r_addr[r_rd];

    // classify the address
    always_comb begin
        w_a64  = {32'd0, i_virt_addr} & ((64'd1 << ADDR_WIDTH) - 64'd1);
        w_pnum = w_a64 >> i_page_shift;
        w_err  = (w_a64 >= {31'd0, i_space_limit}) || (w_pnum >= 64'(VIRT_PAGES));
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_err[r_rd ^ r_cnt[0]]  <= w_err;
            r_addr[r_rd ^ r_cnt[0]] <= w_a64[31:0];
        end
    end
endmodule

// File: src/ptl_back.sv
// ----------------------------------------------------------------------------
// ptl_back
// Looks up the page table, replaces the least recently used frame on a fault
// when no frame is free, and holds the result register.
// ----------------------------------------------------------------------------
module ptl_back #(
    parameter int VIRT_PAGES = 1024,
    parameter int FRAMES     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  logic        i_q_err,
    input  logic [31:0] i_q_addr,
    input  logic [4:0]  i_page_shift,
    input  logic [4:0]  i_frame_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_phys_addr,
    output logic        o_was_hit,
    output logic        o_was_fault,
    output logic        o_range_error,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_fault_total
);
    import ptl_pkg::*;

    localparam int PW = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int EW = FW + 1;

    t_state r_state, n_state;

    logic [PW-1:0]   r_owner [FRAMES];
    logic [63:0]     r_stamp [FRAMES];
    logic [CW-1:0]   r_filled;
    logic [63:0]     r_time;
    logic [31:0]     r_hits, r_faults;
    logic [PW-1:0]   r_page;
    logic [31:0]     r_offset;
    logic [FW-1:0]   r_best;
    logic [CW-1:0]   r_idx;
    logic [PW-1:0]   r_clr;
    logic [31:0]     r_phys;
    logic            r_hit, r_fault, r_err;
    logic            r_out_v;
    logic [31:0]     r_out_phys;
    logic            r_out_hit, r_out_fault, r_out_err;
    logic [31:0]     r_out_hits, r_out_faults;

    logic            w_pt_we;
    logic [PW-1:0]   w_pt_addr;
    logic [EW-1:0]   w_pt_wdata, w_pt_rdata;
    logic            w_pt_valid;
    logic [FW-1:0]   w_pt_frame;
    logic [CW-1:0]   w_limit;
    logic            w_out_free;
    logic            w_free_fault;
    logic            w_load;
    logic [63:0]     w_a64;
    logic [FW-1:0]   w_frame;

    // page table word: valid bit over frame number
    ptl_ram #(.WIDTH(EW), .DEPTH(VIRT_PAGES)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_pt_we),
        .i_addr (w_pt_addr),
        .i_wdata(w_pt_wdata),
        .o_rdata(w_pt_rdata)
    );

    assign w_pt_valid   = w_pt_rdata[EW-1];
    assign w_pt_frame   = w_pt_rdata[FW-1:0];
    assign w_frame      = r_filled[FW-1:0];
    assign w_free_fault = !w_pt_valid && (r_filled < w_limit);
    assign w_out_free   = !r_out_v || !i_stall;
    assign w_load       = (r_state == ST_DONE) && w_out_free;

    assign o_valid       = r_out_v;
    assign o_phys_addr   = r_out_phys;
    assign o_was_hit     = r_out_hit;
    assign o_was_fault   = r_out_fault;
    assign o_range_error = r_out_err;
    assign o_hit_total   = r_out_hits;
    assign o_fault_total = r_out_faults;

    // active frame limit
    always_comb begin
        if (i_frame_count == 5'd0) begin
            w_limit = CW'(1);
        end else if (32'(i_frame_count) > FRAMES) begin
            w_limit = CW'(FRAMES);
        end else begin
            w_limit = CW'(i_frame_count);
        end
        w_a64 = {32'd0, i_q_addr} >> i_page_shift;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == PW'(VIRT_PAGES - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_q_valid) n_state = i_q_err ? ST_DONE : ST_READ;
            ST_READ:  n_state = ST_LOOK;
            ST_LOOK:  if (w_pt_valid || w_free_fault) begin
                          n_state = ST_DONE;
                      end else begin
                          n_state = ST_SCAN;
                      end
            ST_SCAN:  if (r_idx >= w_limit - CW'(1)) n_state = ST_INVAL;
            ST_INVAL: n_state = ST_EVICT;
            ST_EVICT: n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs to the queue and table
    always_comb begin
        o_q_pop    = w_load;
        w_pt_addr  = r_page;
        w_pt_we    = 1'b0;
        w_pt_wdata = {1'b1, r_best};
        if (r_state == ST_CLEAR) begin
            w_pt_addr  = r_clr;
            w_pt_we    = 1'b1;
            w_pt_wdata = '0;
        end else if (r_state == ST_LOOK && w_free_fault) begin
            w_pt_we    = 1'b1;
            w_pt_wdata = {1'b1, w_frame};
        end else if (r_state == ST_INVAL) begin
            w_pt_addr  = r_owner[r_best];
            w_pt_we    = 1'b1;
            w_pt_wdata = '0;
        end else if (r_state == ST_EVICT) begin
            w_pt_we    = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_filled     <= '0;
            r_time       <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
            r_out_v      <= 1'b0;
            r_out_hits   <= '0;
            r_out_faults <= '0;
        end else begin
            r_state <= n_state;
            // output register: load a finished result, drop a taken one
            if (w_load) begin
                r_out_v      <= 1'b1;
                r_out_phys   <= r_phys;
                r_out_hit    <= r_hit;
                r_out_fault  <= r_fault;
                r_out_err    <= r_err;
                r_out_hits   <= r_hits;
                r_out_faults <= r_faults;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: r_clr <= r_clr + PW'(1);
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_page   <= w_a64[PW-1:0];
                        r_offset <= i_q_addr & ((32'd1 << i_page_shift) - 32'd1);
                        r_phys   <= '0;
                        r_hit    <= 1'b0;
                        r_fault  <= 1'b0;
                        r_err    <= i_q_err;
                    end
                end
                ST_READ: r_time <= r_time + 64'd1;
                ST_LOOK: begin
                    r_best <= '0;
                    r_idx  <= CW'(1);
                    if (w_pt_valid) begin
                        r_hits  <= r_hits + 32'd1;
                        r_hit   <= 1'b1;
                        r_stamp[w_pt_frame] <= r_time;
                        r_phys  <= 32'({32'd0, w_pt_frame} << i_page_shift) + r_offset;
                    end else begin
                        r_faults <= r_faults + 32'd1;
                        r_fault  <= 1'b1;
                        if (r_filled < w_limit) begin
                            r_filled         <= r_filled + CW'(1);
                            r_owner[w_frame] <= r_page;
                            r_stamp[w_frame] <= r_time;
                            r_phys <= 32'({32'd0, w_frame} << i_page_shift) + r_offset;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_idx < w_limit) begin
                        if (r_stamp[r_idx[FW-1:0]] < r_stamp[r_best]) begin
                            r_best <= r_idx[FW-1:0];
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_INVAL: ;
                ST_EVICT: begin
                    r_owner[r_best] <= r_page;
                    r_stamp[r_best] <= r_time;
                    r_phys <= 32'({32'd0, r_best} << i_page_shift) + r_offset;
                end
                ST_DONE: ;
                default: ;
            endcase
        end
    end
endmodule

// File: src/page_translate_lru_top.sv
// ----------------------------------------------------------------------------
// page_translate_lru_top
// Demand-paged address translation with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one virtual address per transfer.
// Output channel: o_valid / i_stall carry one translated result per input,
// with physical address, hit, fault and range flags and running totals.
// The front end checks the range and queues up to two addresses; the back
// end runs a sequencer over the page-table RAM, whose words hold a valid
// bit and a frame number.
// A hit or a fault into a free frame is settled by the table read and lookup;
// an eviction adds the one-frame-per-cycle timestamp scan and two table
// writes, and a range error skips the table altogether.
// The output register holds its result while i_stall is high; the back end
// then waits with its next result and the front queue fills and stalls.
// After reset a clearing pass writes every page-table word, one per cycle,
// before the first address is served; counters and the fill count clear
// at once. Configuration is to be written over APB while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module page_translate_lru_top #(
    parameter int VIRT_PAGES = 1024,
    parameter int FRAMES     = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_virt_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_phys_addr,
    output logic        o_was_hit,
    output logic        o_was_fault,
    output logic        o_range_error,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_fault_total
);
    import ptl_pkg::*;

    logic [32:0] r_space_limit;
    logic [4:0]  r_page_shift;
    logic [4:0]  r_frame_count;
    logic        w_q_valid, w_q_pop, w_q_err;
    logic [31:0] w_q_addr;

    assign pready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_limit <= 33'h1_0000_0000;
            r_page_shift  <= 5'd12;
            r_frame_count <= 5'd16;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:3])
                REG_SPACE_LIMIT: r_space_limit <= pwdata[32:0];
                REG_PAGE_SHIFT:  r_page_shift  <= pwdata[4:0];
                REG_FRAME_COUNT: r_frame_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:3])
            REG_SPACE_LIMIT: prdata = {31'd0, r_space_limit};
            REG_PAGE_SHIFT:  prdata = {59'd0, r_page_shift};
            REG_FRAME_COUNT: prdata = {59'd0, r_frame_count};
            default:         prdata = '0;
        endcase
    end

    ptl_front #(.VIRT_PAGES(VIRT_PAGES), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_virt_addr  (i_virt_addr),
        .i_space_limit(r_space_limit),
        .i_page_shift (r_page_shift),
        .o_q_valid    (w_q_valid),
        .i_q_pop      (w_q_pop),
        .o_q_err      (w_q_err),
        .o_q_addr     (w_q_addr)
    );

    ptl_back #(.VIRT_PAGES(VIRT_PAGES), .FRAMES(FRAMES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_err      (w_q_err),
        .i_q_addr     (w_q_addr),
        .i_page_shift (r_page_shift),
        .i_frame_count(r_frame_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_phys_addr  (o_phys_addr),
        .o_was_hit    (o_was_hit),
        .o_was_fault  (o_was_fault),
        .o_range_error(o_range_error),
        .o_hit_total  (o_hit_total),
        .o_fault_total(o_fault_total)
    );

    // a result carries exactly one of hit, fault and range error
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_was_hit, o_was_fault, o_range_error}))
        else $error("result flags not one-hot");

    // an error result leaves the physical address at zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_phys_addr == 32'd0))
        else $error("error result with nonzero address");

    // the hit total moves by at most one between results
    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_hit_total) |-> (o_hit_total == $past(o_hit_total) + 32'd1))
        else $error("hit total jumped");
endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page translation block with LRU replacement.
// ----------------------------------------------------------------------------
// Addresses are sent over the valid/stall input channel. Each accepted address
// is run through a local translation model holding its own page table, frame
// owners and access stamps. Results from the output channel are compared
// field by field in order. Both channels idle in random bursts. The receiver
// holds off once for a long stretch so the block backs up. The run steps
// through several register settings written over APB while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import ptl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES     = 1024;
    localparam int NFRAMES    = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic [31:0] phys_addr;
        logic        was_hit;
        logic        was_fault;
        logic        range_error;
        logic [31:0] hit_total;
        logic [31:0] fault_total;
    } t_xlate;

    // translation model and in-order store of expected results
    class xlate_scoreboard;
        logic [32:0] space_limit;
        logic [4:0]  page_shift;
        logic [4:0]  frame_count;
        bit          page_valid [NPAGES];
        logic [3:0]  page_frame [NPAGES];
        logic [9:0]  frame_owner [NFRAMES];
        logic [63:0] frame_stamp [NFRAMES];
        int          frames_filled;
        logic [63:0] access_time;
        logic [31:0] hit_count;
        logic [31:0] fault_count;
        t_xlate      pending_results [$];
        int          errors;

        function new();
            space_limit   = 33'h1_0000_0000;
            page_shift    = 5'd12;
            frame_count   = 5'd16;
            frames_filled = 0;
            access_time   = '0;
            hit_count     = '0;
            fault_count   = '0;
            errors        = 0;
            foreach (page_valid[i]) page_valid[i] = 0;
        endfunction

        // pick a frame on a fault: next free one, else oldest stamp below limit
        function int claim_frame(int page);
            int limit;
            int oldest;
            limit = (frame_count == 0) ? 1 : ((frame_count > NFRAMES) ? NFRAMES : frame_count);
            fault_count++;
            if (frames_filled < limit) begin
                oldest = frames_filled;
                frames_filled++;
                frame_owner[oldest] = page[9:0];
                return oldest;
            end
            oldest = 0;
            for (int i = 1; i < limit; i++)
                if (frame_stamp[i] < frame_stamp[oldest]) oldest = i;
            page_valid[frame_owner[oldest]] = 0;
            frame_owner[oldest] = page[9:0];
            return oldest;
        endfunction

        // accepted input transfer: translate and queue the expected result
        function void note_addr(logic [31:0] addr);
            logic [63:0] pnum;
            logic [63:0] offset;
            logic [63:0] phys;
            int          frame;
            t_xlate      r;
            pnum   = {32'd0, addr} >> page_shift;
            offset = {32'd0, addr} & ((64'd1 << page_shift) - 64'd1);
            r = '0;
            if ({1'b0, addr} >= space_limit || pnum >= NPAGES) begin
                r.range_error = 1'b1;
            end else begin
                access_time++;
                if (page_valid[pnum]) begin
                    hit_count++;
                    frame = page_frame[pnum];
                    r.was_hit = 1'b1;
                end else begin
                    frame = claim_frame(int'(pnum));
                    page_valid[pnum] = 1;
                    page_frame[pnum] = frame[3:0];
                    r.was_fault = 1'b1;
                end
                frame_stamp[frame] = access_time;
                phys = (64'(frame) << page_shift) + offset;
                r.phys_addr = phys[31:0];
            end
            r.hit_total   = hit_count;
            r.fault_total = fault_count;
            pending_results.push_back(r);
        endfunction

        // accepted output transfer: compare with the oldest expectation
        function void check_result(t_xlate got);
            t_xlate want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result phys=%h", $time, got.phys_addr);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.phys_addr !== want.phys_addr) begin
                $display("%0t: phys_addr exp %h got %h", $time, want.phys_addr, got.phys_addr);
                errors++;
            end
            if (got.was_hit !== want.was_hit) begin
                $display("%0t: was_hit exp %b got %b", $time, want.was_hit, got.was_hit);
                errors++;
            end
            if (got.was_fault !== want.was_fault) begin
                $display("%0t: was_fault exp %b got %b", $time, want.was_fault, got.was_fault);
                errors++;
            end
            if (got.range_error !== want.range_error) begin
                $display("%0t: range_error exp %b got %b", $time, want.range_error,
                         got.range_error);
                errors++;
            end
            if (got.hit_total !== want.hit_total) begin
                $display("%0t: hit_total exp %0d got %0d", $time, want.hit_total, got.hit_total);
                errors++;
            end
            if (got.fault_total !== want.fault_total) begin
                $display("%0t: fault_total exp %0d got %0d", $time, want.fault_total,
                         got.fault_total);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_virt_addr;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_phys_addr;
    logic        o_was_hit;
    logic        o_was_fault;
    logic        o_range_error;
    logic [31:0] o_hit_total;
    logic [31:0] o_fault_total;

    xlate_scoreboard sb = new();
    bit quiet;
    bit hold_req;
    int cycle_count;

    page_translate_lru_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_virt_addr  (i_virt_addr),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_phys_addr  (o_phys_addr),
        .o_was_hit    (o_was_hit),
        .o_was_fault  (o_was_fault),
        .o_range_error(o_range_error),
        .o_hit_total  (o_hit_total),
        .o_fault_total(o_fault_total)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // transfer monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_addr(i_virt_addr);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_phys_addr, o_was_hit, o_was_fault, o_range_error,
                             o_hit_total, o_fault_total});
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // one address transfer, with an optional idle burst ahead of it
    task automatic send_addr(logic [31:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_virt_addr <= addr;
        do @(posedge i_clk); while (o_stall);
    endtask

    // register write over APB, mirrored in the model, then read back
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SPACE_LIMIT: begin
                sb.space_limit = value[32:0];
                want = {31'd0, value[32:0]};
            end
            REG_PAGE_SHIFT: begin
                sb.page_shift = value[4:0];
                want = {59'd0, value[4:0]};
            end
            REG_FRAME_COUNT: begin
                sb.frame_count = value[4:0];
                want = {59'd0, value[4:0]};
            end
            default: want = '0;
        endcase
        @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: readback exp %h got %h", $time, want, prdata);
            sb.errors++;
        end
    endtask

    // let every expected result come back, then let the sequencer settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // mostly a small working set of pages, some near the top, some noise
    function automatic logic [31:0] pick_addr(int span);
        logic [63:0] page;
        logic [63:0] offset;
        logic [63:0] full;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return $urandom();
        page   = (pick == 2) ? 64'(1023 - $urandom_range(0, 3)) : 64'($urandom_range(0, span - 1));
        offset = {32'd0, $urandom()} & ((64'd1 << sb.page_shift) - 64'd1);
        full   = (page << sb.page_shift) | offset;
        return full[31:0];
    endfunction

    task automatic random_run(int count, int span);
        repeat (count) send_addr(pick_addr(span));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_virt_addr = '0;
        quiet       = 0;
        hold_req    = 0;
        cycle_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: first fault, hit, top page, out-of-table and all-ones
        send_addr(32'h0000_0000);
        send_addr(32'h0000_0FFF);
        send_addr(32'h003F_FFFF);
        send_addr(32'h0040_0000);
        send_addr(32'hFFFF_FFFF);
        for (int p = 1; p <= 16; p++)
            send_addr(32'(p) << 12 | 32'h0000_0ABC);
        send_addr(32'h0000_0123);
        send_addr(32'h0000_1000);
        random_run(130, 24);
        drain();

        // byte pages, single frame, tight address space
        write_reg(REG_SPACE_LIMIT, 64'd700);
        write_reg(REG_PAGE_SHIFT, 64'd0);
        write_reg(REG_FRAME_COUNT, 64'd1);
        send_addr(32'd699);
        send_addr(32'd700);
        send_addr(32'd699);
        random_run(100, 4);
        drain();

        // largest nominal pages, frame count zero acts as one
        write_reg(REG_SPACE_LIMIT, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_PAGE_SHIFT, 64'd22);
        write_reg(REG_FRAME_COUNT, 64'd0);
        send_addr(32'hFFFF_FFFE);
        send_addr(32'hFFFF_FFFF);
        random_run(90, 6);
        drain();

        // oversized shift, frame count above the frame total
        write_reg(REG_PAGE_SHIFT, 64'd31);
        write_reg(REG_FRAME_COUNT, 64'd31);
        write_reg(REG_SPACE_LIMIT, 64'd1);
        random_run(40, 2);
        drain();

        // long receiver hold-off so the block backs up, full address space
        write_reg(REG_SPACE_LIMIT, 64'h0000_0001_0000_0000);
        write_reg(REG_PAGE_SHIFT, 64'd7);
        write_reg(REG_FRAME_COUNT, 64'd16);
        hold_req = 1;
        random_run(170, 30);
        drain();

        // frame count lowered while frames above it still hold pages
        write_reg(REG_FRAME_COUNT, 64'd5);
        random_run(100, 30);
        quiet = 1;
        random_run(120, 30);
        drain();

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
